### src/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg - shared types and constants of the keyframe curve evaluator
// Command and status words between controller and datapath, field codes.
// ----------------------------------------------------------------------------
package kce_pkg;

  // action field codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // key interpolation codes (anything else interpolates as cubic)
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;

  // configuration register indexes
  localparam logic REG_KEY_COUNT  = 1'b0;
  localparam logic REG_COMP_COUNT = 1'b1;

  localparam logic [6:0] KEY_COUNT_RESET  = 7'd1;
  localparam logic [2:0] COMP_COUNT_RESET = 3'd1;

  // quotient bits of the fraction u (Q0.30)
  localparam int          DIV_STEPS = 30;
  localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

  typedef enum logic [1:0] {
    TA_ZERO,
    TA_LAST,
    TA_SCAN,
    TA_NEXT
  } taddr_sel_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_UU,
    MUL_U2U,
    MUL_H10DT,
    MUL_H11DT,
    MUL_LIN,
    MUL_H00VA,
    MUL_H01VB,
    MUL_S10OS,
    MUL_S11IS
  } mul_sel_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_U2,
    DST_U3,
    DST_S10,
    DST_S11,
    DST_ACC_VA,
    DST_ACC_LIN,
    DST_ACC_SET30,
    DST_ACC_ADD30,
    DST_ACC_ADD16
  } dst_sel_t;

  typedef struct packed {
    logic       take;      // input word accepted this cycle
    taddr_sel_t taddr;     // time store read address
    logic       ld_t0;
    logic       chk;       // clamp check against first and last key
    logic       scan;      // one step of the bracket search
    logic       div_init;
    logic       div_step;
    logic       h_load;    // build the Hermite basis
    logic       vslot_b;   // value store reads key b instead of key a
    logic       ld_a;
    logic       ld_b;
    mul_sel_t   mul;
    dst_sel_t   dst;
    logic       out_load;  // push one result word
  } cmd_t;

  typedef struct packed {
    logic clamp;
    logic found;
    logic hold;
    logic linear;
    logic div_done;
    logic comp_last;
    logic out_free;
  } sts_t;

endpackage

### src/keyframe_curve_evaluator.sv
// ----------------------------------------------------------------------------
// keyframe_curve_evaluator - hold/linear/cubic Hermite keyframe curve, Q16.16
// Write word: stored on acceptance. Query: clamp check against the first and
// last key; a bracketed time then searches the keys in order and checks the
// mode, then divides (linear) or divides and builds the basis (cubic); then
// each component is emitted held, linear or cubic, waiting while the output
// register is full. One word in flight, set by the 30-step divider and the
// single shared multiplier. Sync reset clears control and config only.
// ----------------------------------------------------------------------------
module keyframe_curve_evaluator #(
  parameter int MAX_KEYS       = 64,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_index[5:0], component[7:6], key_time[39:8], mode[41:40],
  // key_value[73:42], slope_in[105:74], slope_out[137:106],
  // query_time[169:138], zero pad [175:170]
  input  logic [175:0] in_tdata,
  input  logic         in_tuser,   // action
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // out_component[1:0], out_value[33:2], pad [39:34]
  output logic         out_tuser,  // overflow
  output logic         out_tlast,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  kce_pkg::cmd_t cmd;
  kce_pkg::sts_t sts;

  logic [6:0]         key_count_r;
  logic [2:0]         comp_count_r;
  logic               cfg_wr;
  logic [1:0]         res_comp;
  logic signed [31:0] res_value;

  // register file: key_count at 0x0, component_count at 0x4
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= kce_pkg::KEY_COUNT_RESET;
      comp_count_r <= kce_pkg::COMP_COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        kce_pkg::REG_KEY_COUNT:  key_count_r  <= cfg_pwdata[6:0];
        kce_pkg::REG_COMP_COUNT: comp_count_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      kce_pkg::REG_KEY_COUNT:  cfg_prdata = {25'b0, key_count_r};
      kce_pkg::REG_COMP_COUNT: cfg_prdata = {29'b0, comp_count_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // sequencer: one word at a time
  kce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .in_ready  (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stores, divider, multiplier and output register
  kce_dp #(
    .MAX_KEYS       (MAX_KEYS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .key_count       (key_count_r),
    .component_count (comp_count_r),
    .in_action       (in_tuser),
    .in_key_index    (in_tdata[5:0]),
    .in_component    (in_tdata[7:6]),
    .in_key_time     (in_tdata[39:8]),
    .in_mode         (in_tdata[41:40]),
    .in_key_value    (in_tdata[73:42]),
    .in_slope_in     (in_tdata[105:74]),
    .in_slope_out    (in_tdata[137:106]),
    .in_query_time   (in_tdata[169:138]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_component   (res_comp),
    .out_value       (res_value),
    .out_overflow    (out_tuser),
    .out_last        (out_tlast)
  );

  assign out_tdata = {6'b0, res_value, res_comp};

endmodule

### src/kce_ram.sv
// ----------------------------------------------------------------------------
// kce_ram - simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/kce_dp.sv
// ----------------------------------------------------------------------------
// kce_dp - keyframe evaluator datapath
// Key stores, bracket search compare, radix-2 divider, shared multiplier,
// accumulator, saturation and the output register.
// ----------------------------------------------------------------------------
module kce_dp #(
  parameter int MAX_KEYS       = 64,
  parameter int MAX_COMPONENTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kce_pkg::cmd_t       cmd,
  output kce_pkg::sts_t       sts,
  input  logic [6:0]          key_count,
  input  logic [2:0]          component_count,
  input  logic                in_action,
  input  logic [5:0]          in_key_index,
  input  logic [1:0]          in_component,
  input  logic signed [31:0]  in_key_time,
  input  logic [1:0]          in_mode,
  input  logic signed [31:0]  in_key_value,
  input  logic signed [31:0]  in_slope_in,
  input  logic signed [31:0]  in_slope_out,
  input  logic signed [31:0]  in_query_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_component,
  output logic signed [31:0]  out_value,
  output logic                out_overflow,
  output logic                out_last
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int SD = MAX_KEYS * MAX_COMPONENTS;
  localparam int SW = $clog2(SD);

  function automatic logic [SW-1:0] slot(input logic [KW-1:0] k, input logic [1:0] c);
    slot = SW'(int'(k) * MAX_COMPONENTS + int'(c));
  endfunction

  logic signed [31:0] q_r, t0_r, tprev_r, ta_r, tb_r;
  logic [KW-1:0]      nm1_r, i_r, a_r, r_r;
  logic [1:0]         ccm1_r, comp_r;
  logic [32:0]        dt_r, rem_r;
  logic [29:0]        u_r, u2_r, u3_r;
  logic [4:0]         cnt_r;
  logic signed [33:0] h00_r, h01_r, h10_r, h11_r, s10_r, s11_r;
  logic signed [31:0] va_r, vb_r, os_r, is_r;
  logic signed [69:0] p_r;
  logic signed [47:0] acc_r;

  logic               out_valid_r, out_ovf_r, out_last_r;
  logic [1:0]         out_comp_r;
  logic [31:0]        out_value_r;

  logic               wr, ld_q, key_ok, comp_ok;
  logic [KW-1:0]      t_raddr;
  logic signed [31:0] t_rd;
  logic [1:0]         mode_rd;
  logic signed [31:0] v_rd, is_rd, os_rd;
  logic [SW-1:0]      w_slot, v_raddr;
  logic [KW-1:0]      nm1_nxt;
  logic [1:0]         ccm1_nxt;
  logic signed [32:0] dt_w, num_w;
  logic [33:0]        rem2_w;
  logic               ge_w;
  logic signed [33:0] su, su2, su3;
  logic signed [34:0] ma, mb;
  logic               sat_hi, sat_lo;
  logic [31:0]        sat_value;

  // ---- key stores -------------------------------------------------------
  assign key_ok  = int'(in_key_index) < MAX_KEYS;
  assign comp_ok = int'(in_component) < MAX_COMPONENTS;
  assign wr      = cmd.take && (in_action == kce_pkg::ACT_WRITE) && key_ok && comp_ok;
  assign ld_q    = cmd.take && (in_action == kce_pkg::ACT_QUERY);
  assign w_slot  = slot(KW'(in_key_index), in_component);
  assign v_raddr = slot(cmd.vslot_b ? r_r : a_r, comp_r);

  always_comb begin
    case (cmd.taddr)
      kce_pkg::TA_ZERO: t_raddr = '0;
      kce_pkg::TA_LAST: t_raddr = nm1_r;
      kce_pkg::TA_SCAN: t_raddr = i_r;
      default:          t_raddr = KW'(i_r + 1'b1);
    endcase
  end

  kce_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_time (
    .clk(clk), .we(wr), .waddr(KW'(in_key_index)), .wdata(in_key_time),
    .raddr(t_raddr), .rdata(t_rd)
  );

  kce_ram #(.WIDTH(2), .DEPTH(MAX_KEYS)) u_mode (
    .clk(clk), .we(wr), .waddr(KW'(in_key_index)), .wdata(in_mode),
    .raddr(a_r), .rdata(mode_rd)
  );

  kce_ram #(.WIDTH(32), .DEPTH(SD)) u_value (
    .clk(clk), .we(wr), .waddr(w_slot), .wdata(in_key_value),
    .raddr(v_raddr), .rdata(v_rd)
  );

  kce_ram #(.WIDTH(32), .DEPTH(SD)) u_slope_in (
    .clk(clk), .we(wr), .waddr(w_slot), .wdata(in_slope_in),
    .raddr(slot(r_r, comp_r)), .rdata(is_rd)
  );

  kce_ram #(.WIDTH(32), .DEPTH(SD)) u_slope_out (
    .clk(clk), .we(wr), .waddr(w_slot), .wdata(in_slope_out),
    .raddr(slot(a_r, comp_r)), .rdata(os_rd)
  );

  // ---- effective counts ---------------------------------------------------
  always_comb begin
    int n, c;
    n = int'(key_count);
    if (n == 0) n = 1;
    if (n > MAX_KEYS) n = MAX_KEYS;
    c = int'(component_count);
    if (c == 0) c = 1;
    if (c > MAX_COMPONENTS) c = MAX_COMPONENTS;
    nm1_nxt  = KW'(n - 1);
    ccm1_nxt = 2'(c - 1);
  end

  // ---- divider and basis --------------------------------------------------
  assign dt_w   = 33'(tb_r) - 33'(ta_r);
  assign num_w  = 33'(q_r) - 33'(ta_r);
  assign rem2_w = {rem_r, 1'b0};
  assign ge_w   = rem2_w >= {1'b0, dt_r};

  assign su  = $signed({4'b0, u_r});
  assign su2 = $signed({4'b0, u2_r});
  assign su3 = $signed({4'b0, u3_r});

  // ---- shared multiplier operands -----------------------------------------
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul)
      kce_pkg::MUL_UU:    begin ma = {5'b0, u_r};  mb = {5'b0, u_r}; end
      kce_pkg::MUL_U2U:   begin ma = {5'b0, u2_r}; mb = {5'b0, u_r}; end
      kce_pkg::MUL_H10DT: begin ma = 35'(h10_r);  mb = {2'b0, dt_r}; end
      kce_pkg::MUL_H11DT: begin ma = 35'(h11_r);  mb = {2'b0, dt_r}; end
      kce_pkg::MUL_LIN:   begin ma = 35'(vb_r) - 35'(va_r); mb = {5'b0, u_r}; end
      kce_pkg::MUL_H00VA: begin ma = 35'(h00_r);  mb = 35'(va_r); end
      kce_pkg::MUL_H01VB: begin ma = 35'(h01_r);  mb = 35'(vb_r); end
      kce_pkg::MUL_S10OS: begin ma = 35'(s10_r);  mb = 35'(os_r); end
      kce_pkg::MUL_S11IS: begin ma = 35'(s11_r);  mb = 35'(is_r); end
      default:            begin ma = '0;          mb = '0; end
    endcase
  end

  // ---- payload registers --------------------------------------------------
  always_ff @(posedge clk) begin
    p_r <= 70'(ma) * 70'(mb);

    if (ld_q) begin
      q_r    <= in_query_time;
      nm1_r  <= nm1_nxt;
      ccm1_r <= ccm1_nxt;
      i_r    <= KW'(1);
      comp_r <= '0;
    end
    if (cmd.ld_t0) t0_r <= t_rd;
    if (cmd.chk) begin
      tprev_r <= t0_r;
      a_r     <= (q_r <= t0_r) ? '0 : nm1_r;
      r_r     <= (q_r <= t0_r) ? '0 : nm1_r;
    end
    if (cmd.scan) begin
      if (q_r < t_rd) begin
        a_r  <= KW'(i_r - 1'b1);
        r_r  <= i_r;
        ta_r <= tprev_r;
        tb_r <= t_rd;
      end else begin
        tprev_r <= t_rd;
        i_r     <= KW'(i_r + 1'b1);
      end
    end
    if (cmd.div_init) begin
      dt_r  <= dt_w[32:0];
      rem_r <= num_w[32:0];
      u_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= ge_w ? 33'(rem2_w - {1'b0, dt_r}) : rem2_w[32:0];
      u_r   <= {u_r[28:0], ge_w};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.h_load) begin
      h00_r <= (su3 <<< 1) - (su2 + (su2 <<< 1)) + kce_pkg::ONE_Q30;
      h10_r <= su3 - (su2 <<< 1) + su;
      h01_r <= (su2 + (su2 <<< 1)) - (su3 <<< 1);
      h11_r <= su3 - su2;
    end
    if (cmd.ld_a) begin
      va_r <= v_rd;
      os_r <= os_rd;
    end
    if (cmd.ld_b) begin
      vb_r <= v_rd;
      is_r <= is_rd;
    end

    case (cmd.dst)
      kce_pkg::DST_U2:        u2_r  <= p_r[59:30];
      kce_pkg::DST_U3:        u3_r  <= p_r[59:30];
      kce_pkg::DST_S10:       s10_r <= 34'(p_r >>> 30);
      kce_pkg::DST_S11:       s11_r <= 34'(p_r >>> 30);
      kce_pkg::DST_ACC_VA:    acc_r <= 48'(va_r);
      kce_pkg::DST_ACC_LIN:   acc_r <= 48'(va_r) + 48'(p_r >>> 30);
      kce_pkg::DST_ACC_SET30: acc_r <= 48'(p_r >>> 30);
      kce_pkg::DST_ACC_ADD30: acc_r <= acc_r + 48'(p_r >>> 30);
      kce_pkg::DST_ACC_ADD16: acc_r <= acc_r + 48'(p_r >>> 16);
      default:                ;
    endcase

    if (cmd.out_load) begin
      comp_r      <= comp_r + 2'd1;
      out_comp_r  <= comp_r;
      out_value_r <= sat_value;
      out_ovf_r   <= sat_hi | sat_lo;
      out_last_r  <= comp_r == ccm1_r;
    end
  end

  // ---- saturation and output word ----------------------------------------
  assign sat_hi    = acc_r > kce_pkg::SAT_MAX;
  assign sat_lo    = acc_r < kce_pkg::SAT_MIN;
  assign sat_value = sat_hi ? 32'h7fff_ffff : (sat_lo ? 32'h8000_0000 : acc_r[31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_component = out_comp_r;
  assign out_value     = out_value_r;
  assign out_overflow  = out_ovf_r;
  assign out_last      = out_last_r;

  // ---- status -------------------------------------------------------------
  assign sts.clamp     = (q_r <= t0_r) || (q_r >= t_rd);
  assign sts.found     = q_r < t_rd;
  assign sts.hold      = (q_r == ta_r) || (mode_rd == kce_pkg::MODE_HOLD);
  assign sts.linear    = mode_rd == kce_pkg::MODE_LINEAR;
  assign sts.div_done  = cnt_r == kce_pkg::DIV_LAST;
  assign sts.comp_last = comp_r == ccm1_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

### src/kce_ctrl.sv
// ----------------------------------------------------------------------------
// kce_ctrl - keyframe evaluator sequencer
// Steps one word at a time through search, divide, basis and per-component
// accumulation, issuing datapath commands.
// ----------------------------------------------------------------------------
module kce_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  output kce_pkg::cmd_t cmd,
  input  kce_pkg::sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_SCAN, S_MODE, S_MCHK, S_DIV,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
    S_CA, S_CB, S_CC, S_L1, S_L2,
    S_K1, S_K2, S_K3, S_K4, S_K5, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    K_HOLD,
    K_LIN,
    K_CUB
  } kind_t;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_HOLD;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.take  = in_valid;
        cmd.taddr = kce_pkg::TA_ZERO;
        if (in_valid && in_action == kce_pkg::ACT_QUERY) state_nxt = S_T1;
      end
      S_T1: begin
        cmd.ld_t0 = 1'b1;
        cmd.taddr = kce_pkg::TA_LAST;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.chk   = 1'b1;
        cmd.taddr = kce_pkg::TA_SCAN;
        if (sts.clamp) begin
          kind_nxt  = K_HOLD;
          state_nxt = S_CA;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.taddr = kce_pkg::TA_NEXT;
        if (sts.found) state_nxt = S_MODE;
      end
      S_MODE: state_nxt = S_MCHK;
      S_MCHK: begin
        cmd.div_init = 1'b1;
        if (sts.hold) begin
          kind_nxt  = K_HOLD;
          state_nxt = S_CA;
        end else begin
          kind_nxt  = sts.linear ? K_LIN : K_CUB;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = (kind_r == K_LIN) ? S_CA : S_M1;
      end
      S_M1: begin
        cmd.mul   = kce_pkg::MUL_UU;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.dst   = kce_pkg::DST_U2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.mul   = kce_pkg::MUL_U2U;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.dst   = kce_pkg::DST_U3;
        state_nxt = S_M5;
      end
      S_M5: begin
        cmd.h_load = 1'b1;
        state_nxt  = S_M6;
      end
      S_M6: begin
        cmd.mul   = kce_pkg::MUL_H10DT;
        state_nxt = S_M7;
      end
      S_M7: begin
        cmd.mul   = kce_pkg::MUL_H11DT;
        cmd.dst   = kce_pkg::DST_S10;
        state_nxt = S_M8;
      end
      S_M8: begin
        cmd.dst   = kce_pkg::DST_S11;
        state_nxt = S_CA;
      end
      S_CA: state_nxt = S_CB;
      S_CB: begin
        cmd.ld_a    = 1'b1;
        cmd.vslot_b = 1'b1;
        state_nxt   = S_CC;
      end
      S_CC: begin
        cmd.ld_b = 1'b1;
        unique case (kind_r)
          K_HOLD: begin
            cmd.dst   = kce_pkg::DST_ACC_VA;
            state_nxt = S_EMIT;
          end
          K_LIN:   state_nxt = S_L1;
          default: state_nxt = S_K1;
        endcase
      end
      S_L1: begin
        cmd.mul   = kce_pkg::MUL_LIN;
        state_nxt = S_L2;
      end
      S_L2: begin
        cmd.dst   = kce_pkg::DST_ACC_LIN;
        state_nxt = S_EMIT;
      end
      S_K1: begin
        cmd.mul   = kce_pkg::MUL_H00VA;
        state_nxt = S_K2;
      end
      S_K2: begin
        cmd.mul   = kce_pkg::MUL_H01VB;
        cmd.dst   = kce_pkg::DST_ACC_SET30;
        state_nxt = S_K3;
      end
      S_K3: begin
        cmd.mul   = kce_pkg::MUL_S10OS;
        cmd.dst   = kce_pkg::DST_ACC_ADD30;
        state_nxt = S_K4;
      end
      S_K4: begin
        cmd.mul   = kce_pkg::MUL_S11IS;
        cmd.dst   = kce_pkg::DST_ACC_ADD16;
        state_nxt = S_K5;
      end
      S_K5: begin
        cmd.dst   = kce_pkg::DST_ACC_ADD16;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.comp_last ? S_IDLE : S_CA;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### sim/tb_keyframe_curve_evaluator.sv
// ----------------------------------------------------------------------------
// tb_keyframe_curve_evaluator - self-checking bench for the keyframe evaluator
// Fills the key table through write words and fires query words over several
// key/component count settings; each query is predicted in the bench and its
// result words compared per field. Both sides stall at random bar the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyframe_curve_evaluator;

  localparam logic [1:0] MODE_CUBIC = 2'd2;
  localparam logic [1:0] MODE_ALT   = 2'd3;   // spare code, behaves as cubic
  localparam logic [2:0] ADDR_KEY_COUNT  = 3'd0;
  localparam logic [2:0] ADDR_COMP_COUNT = 3'd4;
  localparam int SLOTS = 4;                   // component slots per key
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]         comp;
    logic signed [31:0] value;
    logic               ovf;
    logic               last;
  } curve_word_t;

  // Shadow of the key table plus the curve maths; holds the expected words.
  class curve_scoreboard;
    logic signed [31:0] key_t[64];
    logic [1:0]         key_mode[64];
    logic signed [31:0] val[256];
    logic signed [31:0] slope_i[256];
    logic signed [31:0] slope_o[256];
    int unsigned        n_keys = 1;
    int unsigned        n_comps = 1;
    curve_word_t        pending[$];
    int                 errors = 0;

    function void set_reg(logic idx, int unsigned v);
      if (idx == kce_pkg::REG_KEY_COUNT) n_keys = v & 7'h7f;
      else n_comps = v & 3'h7;
    endfunction

    function void push_value(int unsigned c, longint v, bit last);
      curve_word_t w;
      w.comp = c[1:0];
      w.ovf  = 1'b0;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; w.ovf = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; w.ovf = 1'b1;
      end
      w.value = v[31:0];
      w.last  = last;
      pending.push_back(w);
    endfunction

    function void note_word(logic act, int unsigned ki, int unsigned comp,
                            logic signed [31:0] kt, logic [1:0] md,
                            logic signed [31:0] kv, logic signed [31:0] si,
                            logic signed [31:0] so, logic signed [31:0] qt);
      int unsigned n, cc, a, r, held, slot;
      longint q, dt, num, u, u2, u3, h00, h10, h01, h11, s10, s11, va, vb, v;
      bit interp;
      if (act == kce_pkg::ACT_WRITE) begin
        slot = ki * SLOTS + comp;
        key_t[ki] = kt; key_mode[ki] = md;
        val[slot] = kv; slope_i[slot] = si; slope_o[slot] = so;
        return;
      end
      n  = (n_keys == 0) ? 1 : ((n_keys > 64) ? 64 : n_keys);
      cc = (n_comps == 0) ? 1 : ((n_comps > SLOTS) ? SLOTS : n_comps);
      q = qt;
      interp = 1'b0;
      a = 0; r = 0;
      if (q <= key_t[0]) held = 0;
      else if (q >= key_t[n-1]) held = n - 1;
      else begin
        // first key strictly later than q brackets the segment
        r = n - 1;
        for (int i = 1; i < n; i++)
          if (q < key_t[i]) begin r = i; break; end
        a = r - 1;
        held = a;
        interp = !(q == key_t[a] || key_mode[a] == kce_pkg::MODE_HOLD);
      end
      if (!interp) begin
        for (int i = 0; i < cc; i++)
          push_value(i, val[held*SLOTS+i], i == cc - 1);
        return;
      end
      dt  = longint'(key_t[r]) - longint'(key_t[a]);
      num = q - longint'(key_t[a]);
      u   = (num <<< 30) / dt;
      u2  = (u * u) >>> 30;
      u3  = (u2 * u) >>> 30;
      h00 = 2*u3 - 3*u2 + (64'sd1 <<< 30);
      h10 = u3 - 2*u2 + u;
      h01 = -2*u3 + 3*u2;
      h11 = u3 - u2;
      s10 = (h10 * dt) >>> 30;
      s11 = (h11 * dt) >>> 30;
      for (int i = 0; i < cc; i++) begin
        va = val[a*SLOTS+i];
        vb = val[r*SLOTS+i];
        if (key_mode[a] == kce_pkg::MODE_LINEAR) v = va + (((vb - va) * u) >>> 30);
        else
          v = ((h00 * va) >>> 30) + ((h01 * vb) >>> 30)
            + ((s10 * longint'(slope_o[a*SLOTS+i])) >>> 16)
            + ((s11 * longint'(slope_i[r*SLOTS+i])) >>> 16);
        push_value(i, v, i == cc - 1);
      end
    endfunction

    function void check_result(logic [1:0] comp, logic signed [31:0] value,
                               logic ovf, logic last);
      curve_word_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: comp %0d value %0d ovf %0b last %0b",
                   comp, value, ovf, last);
        return;
      end
      e = pending.pop_front();
      if (e.comp !== comp || e.value !== value || e.ovf !== ovf || e.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp comp %0d value %0d ovf %0b last %0b / got %0d %0d %0b %0b",
                   e.comp, e.value, e.ovf, e.last, comp, value, ovf, last);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  curve_scoreboard sb = new();
  bit calm = 1'b0;                    // no idling on either side when set
  int ready_hold = 0;
  logic signed [31:0] key_times[64];  // local copy of the times just written

  keyframe_curve_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall bursts, none once calm
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(1, 14) - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result words are checked at the edge they are taken
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[1:0], out_tdata[33:2], out_tuser, out_tlast);

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_penable = 1'b0; cfg_pwrite = 1'b1;
    cfg_paddr = addr; cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(addr == ADDR_COMP_COUNT ? kce_pkg::REG_COMP_COUNT : kce_pkg::REG_KEY_COUNT,
               data);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic send_word(logic act, int unsigned ki, int unsigned comp,
                           logic signed [31:0] kt, logic [1:0] md,
                           logic signed [31:0] kv, logic signed [31:0] si,
                           logic signed [31:0] so, logic signed [31:0] qt);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata[5:0] = ki[5:0];       in_tdata[7:6] = comp[1:0];
    in_tdata[39:8] = kt;           in_tdata[41:40] = md;
    in_tdata[73:42] = kv;          in_tdata[105:74] = si;
    in_tdata[137:106] = so;        in_tdata[169:138] = qt;
    in_tuser = act;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_word(act, ki, comp, kt, md, kv, si, so, qt);
  endtask

  // drop valid, let every expected word out, then idle for the drain period
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 1 << 21)) - (1 <<< 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_slope();
    if ($urandom_range(0, 1)) return $signed($urandom_range(0, 1 << 19)) - (1 <<< 18);
    return $urandom;
  endfunction

  // style: 0 spans the whole time range, 1 rising, 2 any order, 3 rising spare mode
  task automatic load_table(int unsigned n, int unsigned cc, int style);
    longint t;
    logic [1:0] md;
    t = longint'($urandom_range(0, 1 << 30)) - (64'sd1 <<< 30);
    for (int k = 0; k < n; k++) begin
      if (style == 0)
        key_times[k] = (n == 1) ? -32'sd2147483648
                     : -64'sd2147483648 + (k * 64'sd4294967295) / (n - 1);
      else if (style == 2)
        key_times[k] = $urandom;
      else begin
        key_times[k] = t;
        t += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 1 << 24);
      end
      md = (style == 0) ? MODE_CUBIC : (style == 3) ? MODE_ALT : 2'($urandom_range(0, 3));
      for (int c = 0; c < cc; c++)
        send_word(kce_pkg::ACT_WRITE, k, c, key_times[k], md,
                  (style == 0) ? ((c % 2) ? 32'sh80000000 : 32'sh7fffffff) : pick_value(),
                  (style == 0) ? 32'sh7fffffff : pick_slope(),
                  (style == 0) ? 32'sh80000000 : pick_slope(), $urandom);
    end
  endtask

  function automatic logic signed [31:0] pick_query(int unsigned n, int kind);
    int unsigned i;
    longint lo, hi, q;
    i = $urandom_range(0, n - 1);
    case (kind)
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return key_times[i];
      4: q = longint'(key_times[0]) - $urandom_range(0, 1000);
      5: q = longint'(key_times[n-1]) + $urandom_range(0, 1000);
      6: return $urandom;
      default: begin
        if (n < 2) return key_times[0];
        i = $urandom_range(0, n - 2);
        lo = key_times[i]; hi = key_times[i+1];
        if (hi <= lo + 1) return key_times[i];
        q = lo + 1 + ({$urandom, $urandom} % (hi - lo - 1));
      end
    endcase
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    return q[31:0];
  endfunction

  // per phase: key_count and component_count as written, table style
  int unsigned phase_kc[8] = '{2, 0, 127, 5, 1, 3, 6, 2};
  int unsigned phase_cc[8] = '{7, 1, 1, 0, 4, 2, 4, 4};
  int          phase_style[8] = '{0, 1, 1, 2, 1, 2, 1, 3};

  initial begin
    int unsigned n, cc;
    int kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < 8; p++) begin
      calm = (p == 7);
      cfg_write(ADDR_KEY_COUNT, phase_kc[p]);
      cfg_write(ADDR_COMP_COUNT, phase_cc[p]);
      n  = (phase_kc[p] == 0) ? 1 : ((phase_kc[p] > 64) ? 64 : phase_kc[p]);
      cc = (phase_cc[p] == 0) ? 1 : ((phase_cc[p] > 4) ? 4 : phase_cc[p]);
      load_table(n, cc, phase_style[p]);
      for (int j = 0; j < 11; j++) begin
        // first phase walks every query kind, later ones favour the in-segment kind
        if (p == 0 && j < 7) kind = j;
        else begin
          kind = $urandom_range(0, 11);
          if (kind > 6) kind = 3;
        end
        send_word(kce_pkg::ACT_QUERY, $urandom_range(0, 63), $urandom_range(0, 3), $urandom,
                  2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  pick_query(n, kind));
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_keyframe_curve_evaluator: clean");
    else
      $display("tb_keyframe_curve_evaluator: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_keyframe_curve_evaluator: errors");
    $finish;
  end

endmodule

### keyframe_curve_evaluator.f
src/kce_pkg.sv
src/kce_ram.sv
src/kce_dp.sv
src/kce_ctrl.sv
src/keyframe_curve_evaluator.sv
sim/tb_keyframe_curve_evaluator.sv
